// ----- rtl/mbps_pkg.sv -----
// Package for the masked byte pattern scanner.
// Holds the word types of both channels, register indexes and fixed limits.
// No dependencies.
package mbps_pkg;

    // field widths fixed by the interface
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 25;
    localparam int COUNT_W  = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_MAX_SLOTS = 16;

    // saturation limits
    localparam logic [COUNT_W-1:0] SEEN_MAX  = 26'h3FF_FFFF;
    localparam logic [COUNT_W-1:0] TOTAL_MAX = 26'h200_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COUNT = 3'd4;

    // result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // input word
    typedef struct packed {
        logic [BYTE_W-1:0] rom_byte;
        logic              last_byte;
    } t_in_word;

    // result word
    typedef struct packed {
        logic                result_kind;
        logic [OFFSET_W-1:0] match_offset;
        logic [COUNT_W-1:0]  match_total;
        logic                count_as_expected;
        logic                final_result;
    } t_out_word;

    // push request from the scanner core to the result queue
    typedef struct packed {
        logic push_first;
        logic push_second;
    } t_push_ctl;

endpackage

// ----- rtl/masked_byte_pattern_scanner_unit.sv -----
// Masked byte pattern scanner, top level.
// Holds the configuration, the byte window and counters, and the match logic.
// Depends on mbps_pkg and mbps_res_fifo.
//
// Usage:
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
//   the block is idle. Image bytes arrive on the input channel (i_valid,
//   o_stall, i_word), one word per byte in address order, last_byte set on
//   the final byte. Results leave on the output channel (o_valid, i_stall,
//   o_word): a match report for every start offset that matches, and on the
//   last byte a summary after any match report of that byte.
//   A result enters the queue as its byte is taken; o_valid is high from the
//   next cycle on. Throughput: one byte per cycle while o_stall is low; the
//   window compare is a single pass of parallel byte compares. A last byte
//   that also matches gives two results, which the output drains at one per
//   cycle while i_stall is low. Results queue in a four-entry buffer; o_stall
//   rises once fewer than two free entries remain, so a stalled receiver
//   holds the input back as soon as three result words are waiting.
//   Reset clears the window, counters and queue and loads the register reset
//   values (expected_count 1, all others 0). The window and counters are
//   also cleared after each last byte; the registers are kept.
module masked_byte_pattern_scanner_unit
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int IMAGE_ADDR_BITS   = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // usable compare slots
    localparam int SLOTS = (MAX_PATTERN_BYTES < PAT_MAX_SLOTS) ? MAX_PATTERN_BYTES
                                                               : PAT_MAX_SLOTS;
    // start offset mask: image address bits, cut to the count width
    localparam logic [COUNT_W-1:0] ADDR_MASK =
        (IMAGE_ADDR_BITS >= COUNT_W) ? {COUNT_W{1'b1}}
                                     : COUNT_W'((64'd1 << IMAGE_ADDR_BITS) - 64'd1);

    // configuration registers
    logic [63:0]        r_pattern_low;
    logic [63:0]        r_pattern_high;
    logic [15:0]        r_wildcard_mask;
    logic [4:0]         r_pattern_length;
    logic [COUNT_W-1:0] r_expected_count;

    // scan state
    logic [BYTE_W-1:0]  r_win [SLOTS];
    logic [BYTE_W-1:0]  n_win [SLOTS];
    logic [COUNT_W-1:0] r_seen, n_seen;
    logic [COUNT_W-1:0] r_matches, n_matches;

    logic               accept;
    logic [127:0]       pattern_all;
    logic               match;
    logic [COUNT_W-1:0] start_ofs;
    logic [2:0]         fifo_count;
    t_push_ctl          push;
    t_out_word          word_a, word_b;
    t_out_word          match_word, summary_word;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = (fifo_count > 3'd2);
    assign pattern_all = {r_pattern_high, r_pattern_low};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_wildcard_mask  <= '0;
            r_pattern_length <= '0;
            r_expected_count <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                CFG_WILDCARD_MASK:  r_wildcard_mask  <= i_cfg_data[15:0];
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[4:0];
                CFG_EXPECTED_COUNT: r_expected_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // window after the new byte, index 0 newest
    always_comb begin
        n_win[0] = i_word.rom_byte;
        for (int k = 1; k < SLOTS; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_seen = (r_seen < SEEN_MAX) ? r_seen + COUNT_W'(1) : r_seen;
    end

    // masked compare: pattern byte i lines up with window byte len-1-i
    always_comb begin
        logic [BYTE_W-1:0] sel;
        logic              all_ok;
        all_ok = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            sel = '0;
            for (int j = 0; j < SLOTS; j++) begin
                if ((i + j + 1) == int'(r_pattern_length)) begin
                    sel = n_win[j];
                end
            end
            if ((i < int'(r_pattern_length)) && !r_wildcard_mask[i]
                && (sel != pattern_all[8*i +: 8])) begin
                all_ok = 1'b0;
            end
        end
        match = all_ok && (r_pattern_length != 5'd0)
                && (int'(r_pattern_length) <= SLOTS)
                && (n_seen >= COUNT_W'(r_pattern_length));
    end

    // counters and result words
    always_comb begin
        n_matches = (match && (r_matches < TOTAL_MAX)) ? r_matches + COUNT_W'(1)
                                                       : r_matches;
        start_ofs = n_seen - COUNT_W'(r_pattern_length);

        match_word.result_kind       = KIND_MATCH;
        match_word.match_offset      = OFFSET_W'(start_ofs & ADDR_MASK);
        match_word.match_total       = n_matches;
        match_word.count_as_expected = 1'b0;
        match_word.final_result      = 1'b0;

        summary_word.result_kind       = KIND_SUMMARY;
        summary_word.match_offset      = '0;
        summary_word.match_total       = n_matches;
        summary_word.count_as_expected = (n_matches == r_expected_count);
        summary_word.final_result      = 1'b1;

        // pack into the queue in order: match first, then summary
        push.push_first  = accept && (match || i_word.last_byte);
        push.push_second = accept && match && i_word.last_byte;
        word_a = match ? match_word : summary_word;
        word_b = summary_word;
    end

    // state update, cleared after a last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_matches <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_win[k] <= '0;
            end
        end else if (accept) begin
            if (i_word.last_byte) begin
                r_seen    <= '0;
                r_matches <= '0;
                for (int k = 0; k < SLOTS; k++) begin
                    r_win[k] <= '0;
                end
            end else begin
                r_seen    <= n_seen;
                r_matches <= n_matches;
                for (int k = 0; k < SLOTS; k++) begin
                    r_win[k] <= n_win[k];
                end
            end
        end
    end

    // result queue
    mbps_res_fifo u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word_a (word_a),
        .i_word_b (word_b),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_word   (o_word),
        .o_count  (fifo_count)
    );

endmodule

// ----- rtl/mbps_res_fifo.sv -----
// Four-entry result queue for the masked byte pattern scanner.
// Takes up to two words per cycle, hands out one while i_stall is low. Depends on mbps_pkg.
module mbps_res_fifo
    import mbps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push_ctl i_push,
    input  t_out_word i_word_a,
    input  t_out_word i_word_b,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word,
    output logic [2:0] o_count
);

    t_out_word  r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count,  n_count;
    logic       pop;
    logic [1:0] push_cnt;

    assign pop      = (r_count != 3'd0) && !i_stall;
    assign push_cnt = {1'b0, i_push.push_first} + {1'b0, i_push.push_second};

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + push_cnt;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage: second word goes behind the first
    always_ff @(posedge i_clk) begin
        if (i_push.push_first) begin
            r_mem[r_wr_ptr] <= i_word_a;
        end
        if (i_push.push_second) begin
            r_mem[r_wr_ptr + {1'b0, i_push.push_first}] <= i_word_b;
        end
    end

    assign o_valid = (r_count != 3'd0);
    assign o_word  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ----- tb/tb_masked_byte_pattern_scanner_unit.sv -----
`timescale 1ns / 100ps
// Testbench for masked_byte_pattern_scanner_unit: streams byte images and checks
// every result word against a scanner model kept inside this file.
// Depends on mbps_pkg and the scanner RTL.
module tb_masked_byte_pattern_scanner_unit;
    import mbps_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 6;
    localparam int TIMEOUT_CYCLES = 300000;

    // DUT ports, all inputs known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_in_word              i_word      = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_out_word             o_word;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // model copy of the registers (reset values)
    logic [63:0]        pat_low_reg     = '0;
    logic [63:0]        pat_high_reg    = '0;
    logic [15:0]        wildcard_reg    = '0;
    logic [4:0]         pat_len_reg     = '0;
    logic [COUNT_W-1:0] expect_reg      = COUNT_W'(1);

    // model copy of the scan state; index 0 holds the newest byte
    logic [BYTE_W-1:0]  recent_bytes [PAT_MAX_SLOTS] = '{default: '0};
    logic [COUNT_W-1:0] bytes_seen      = '0;
    logic [COUNT_W-1:0] matches_found   = '0;

    t_out_word          pending_results [$];
    int                 mismatch_count  = 0;
    int                 snd_idle_pct    = 35;
    int                 rcv_idle_pct    = 65;
    int                 hold_cycles     = 0;

    masked_byte_pattern_scanner_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // pattern byte i of the configured 16-byte pattern
    function automatic logic [BYTE_W-1:0] pattern_byte(input int i);
        logic [127:0] pat;
        pat = {pat_high_reg, pat_low_reg};
        return pat[8*i +: 8];
    endfunction

    // advance the scanner model by one image byte and queue the words it gives
    function automatic void predict_scan(input t_in_word w);
        t_out_word          r;
        logic               hit;
        int                 len;
        int                 k;
        logic [COUNT_W-1:0] start;
        for (k = PAT_MAX_SLOTS - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = w.rom_byte;
        if (bytes_seen != SEEN_MAX) bytes_seen++;
        len = int'(pat_len_reg);
        // empty or overlong pattern never hits; nor does a window not yet full
        hit = (len != 0) && (len <= PAT_MAX_SLOTS) && (bytes_seen >= len);
        for (k = 0; k < len && hit; k++) begin
            if (!wildcard_reg[k] && recent_bytes[len-1-k] != pattern_byte(k)) hit = 1'b0;
        end
        if (hit) begin
            start = bytes_seen - COUNT_W'(len);
            if (matches_found < TOTAL_MAX) matches_found++;
            r = '0;
            r.result_kind  = KIND_MATCH;
            r.match_offset = start[OFFSET_W-1:0];
            r.match_total  = matches_found;
            pending_results.insert(pending_results.size(), r);
        end
        // summary always follows any match on the last byte, then state clears
        if (w.last_byte) begin
            r = '0;
            r.result_kind       = KIND_SUMMARY;
            r.match_total       = matches_found;
            r.count_as_expected = (matches_found == expect_reg);
            r.final_result      = 1'b1;
            pending_results.insert(pending_results.size(), r);
            for (k = 0; k < PAT_MAX_SLOTS; k++) recent_bytes[k] = '0;
            bytes_seen    = '0;
            matches_found = '0;
        end
    endfunction

    // one register write, then the write enable drops again before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PATTERN_LOW:    pat_low_reg  = data;
            CFG_PATTERN_HIGH:   pat_high_reg = data;
            CFG_WILDCARD_MASK:  wildcard_reg = data[15:0];
            CFG_PATTERN_LENGTH: pat_len_reg  = data[4:0];
            CFG_EXPECTED_COUNT: expect_reg   = data[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_scan_config(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [63:0] wild, input logic [63:0] len,
                                   input logic [63:0] expect_total);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_WILDCARD_MASK, wild);
        write_reg(CFG_PATTERN_LENGTH, len);
        write_reg(CFG_EXPECTED_COUNT, expect_total);
    endtask

    // offer one image byte, with random gaps first, and hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] data_byte, input logic is_last);
        t_in_word w;
        w.rom_byte  = data_byte;
        w.last_byte = is_last;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_scan(w);
    endtask

    task automatic send_image(input logic [BYTE_W-1:0] img [$]);
        int pos;
        for (pos = 0; pos < img.size(); pos++) send_byte(img[pos], pos == img.size() - 1);
    endtask

    // wait until every expected word is out and the block has gone quiet
    task automatic settle_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register reset values: empty pattern, expected count one
    task automatic test_reset_defaults();
        send_image('{8'h00, 8'hFF});
        settle_idle();
    endtask

    // hand-picked patterns: wildcard byte, hit on last byte, short image,
    // overlong length, single wildcard byte with unreachable expected count
    task automatic test_fixed_patterns();
        set_scan_config(64'h0000_0000_EFBE_ADDE, 64'h0, 64'h2, 64'd4, 64'd2);
        send_image('{8'hDE, 8'h00, 8'hBE, 8'hEF, 8'hDE, 8'h55, 8'hBE, 8'hEF});
        send_image('{8'hDE, 8'hAD, 8'hBE});
        settle_idle();
        set_scan_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                        64'hFFFF, 64'd31, 64'd0);
        send_image('{8'hA5});
        settle_idle();
        set_scan_config(64'h0, 64'h0, 64'hFFFF, 64'd1, 64'h3FF_FFFF);
        send_image('{8'h80, 8'h7F});
        settle_idle();
    endtask

    // random configurations, images seeded with copies of the pattern
    task automatic test_random_images(input int n_items);
        int                sent;
        int                img_len;
        int                len;
        int                k;
        logic [63:0]       wild;
        logic [63:0]       len_data;
        logic [63:0]       expect_data;
        logic [BYTE_W-1:0] img [$];
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(19))
                0:       len = 0;
                1:       len = $urandom_range(17, 31);
                2, 3:    len = 16;
                4, 5:    len = $urandom_range(6, 15);
                default: len = $urandom_range(1, 5);
            endcase
            // upper data bits are junk the block has to ignore
            wild = {$urandom, $urandom};
            case ($urandom_range(3))
                0: wild[15:0] = '0;
                1: wild[15:0] = 16'($urandom & $urandom & $urandom);
                2: wild[15:0] = 16'($urandom);
                3: wild[15:0] = 16'hFFFF;
            endcase
            len_data      = {$urandom, $urandom};
            len_data[4:0] = 5'(len);
            expect_data   = {$urandom, $urandom};
            expect_data[COUNT_W-1:0] = ($urandom_range(7) == 0) ? 26'h3FF_FFFF
                                                                : COUNT_W'($urandom_range(0, 4));
            set_scan_config({$urandom, $urandom}, {$urandom, $urandom}, wild,
                            len_data, expect_data);

            img_len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            img.delete();
            while (img.size() < img_len) begin
                if (len >= 1 && len <= PAT_MAX_SLOTS && $urandom_range(2) == 0) begin
                    for (k = 0; k < len; k++)
                        img.insert(img.size(),
                                   wildcard_reg[k] ? 8'($urandom) : pattern_byte(k));
                end else if ($urandom_range(1) == 0) begin
                    img.insert(img.size(), pattern_byte($urandom_range(0, PAT_MAX_SLOTS - 1)));
                end else begin
                    img.insert(img.size(), 8'($urandom));
                end
            end
            send_image(img);
            sent += img.size();
            settle_idle();
        end
    endtask

    // receiver holds off for a long stretch while bytes keep coming,
    // every byte hits so the result buffer fills and the input stalls
    task automatic test_output_hold_off();
        int k;
        set_scan_config(64'h0, 64'h0, 64'hFFFF, 64'd1, 64'd40);
        hold_cycles <= 120;
        for (k = 0; k < 40; k++) send_byte(8'(k * 7), k == 39);
        settle_idle();
    endtask

    // receiver side: long hold-off when asked, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // compare each accepted result word with the oldest expected one
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word %h arrived with none expected", o_word);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.result_kind),
                            32'(o_word.result_kind));
                check_field("match_offset", 32'(want.match_offset),
                            32'(o_word.match_offset));
                check_field("match_total", 32'(want.match_total),
                            32'(o_word.match_total));
                check_field("count_as_expected", 32'(want.count_as_expected),
                            32'(o_word.count_as_expected));
                check_field("final_result", 32'(want.final_result),
                            32'(o_word.final_result));
            end
        end
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_fixed_patterns();
        test_random_images(200);
        snd_idle_pct = 65;
        rcv_idle_pct = 35;
        test_random_images(200);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_images(200);
        test_output_hold_off();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Mismatches found");
        $finish;
    end

endmodule
